>>> rtl/tea_pkg.sv
// Shared types and constants for the TEA block cipher.
package tea_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned KEY_CNT = 4;

    // Key schedule constants
    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // Key register reset values
    localparam logic [WORD_W-1:0] KEY0_RST = 32'd1340881873;
    localparam logic [WORD_W-1:0] KEY1_RST = 32'd4272652875;
    localparam logic [WORD_W-1:0] KEY2_RST = 32'd4260980025;
    localparam logic [WORD_W-1:0] KEY3_RST = 32'd7754793;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } t_reg_idx;

    // Direction carried with each block
    typedef enum logic {
        ACT_ENCRYPT = 1'b0,
        ACT_DECRYPT = 1'b1
    } t_action;

    typedef logic [KEY_CNT-1:0][WORD_W-1:0] t_key;

    // One block in flight through the chain
    typedef struct packed {
        t_action           action;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
    } t_blk;

endpackage

>>> rtl/tea_cell.sv
// One half-round cell of the TEA chain, registered at its output.
module tea_cell #(
    parameter logic [31:0] P_SUM_ENC = 32'd0,
    parameter logic [31:0] P_SUM_DEC = 32'd0,
    parameter bit          P_HALF    = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  tea_pkg::t_key i_key,
    input  logic          i_valid,
    input  tea_pkg::t_blk i_blk,
    output logic          o_valid,
    output tea_pkg::t_blk o_blk
);
    import tea_pkg::*;

    logic              w_dec;
    logic              w_upd_v0;
    logic [WORD_W-1:0] w_src;
    logic [WORD_W-1:0] w_dst;
    logic [WORD_W-1:0] w_ka;
    logic [WORD_W-1:0] w_kb;
    logic [WORD_W-1:0] w_sum;
    logic [WORD_W-1:0] w_mix;
    logic [WORD_W-1:0] w_res;
    t_blk              n_blk;
    logic              r_valid;
    t_blk              r_blk;

    // Encrypt updates v0 then v1; decrypt runs the halves in reverse
    assign w_dec    = (i_blk.action == ACT_DECRYPT);
    assign w_upd_v0 = (P_HALF ^ w_dec) == 1'b0;
    assign w_src    = w_upd_v0 ? i_blk.v1 : i_blk.v0;
    assign w_dst    = w_upd_v0 ? i_blk.v0 : i_blk.v1;
    assign w_ka     = w_upd_v0 ? i_key[REG_KEY0] : i_key[REG_KEY2];
    assign w_kb     = w_upd_v0 ? i_key[REG_KEY1] : i_key[REG_KEY3];
    assign w_sum    = w_dec ? P_SUM_DEC : P_SUM_ENC;

    // Mix function and wrapping add or subtract
    assign w_mix = ((w_src << 4) + w_ka) ^ (w_src + w_sum) ^ ((w_src >> 5) + w_kb);
    assign w_res = w_dec ? (w_dst - w_mix) : (w_dst + w_mix);

    always_comb begin
        n_blk = i_blk;
        if (w_upd_v0) begin
            n_blk.v0 = w_res;
        end else begin
            n_blk.v1 = w_res;
        end
    end

    // Valid bit is control, payload is not reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

>>> rtl/tea_outbuf.sv
// Two-entry output buffer between the cell chain and the result stream.
module tea_outbuf (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [63:0] i_data,
    output logic        o_full,
    output logic        o_valid,
    output logic [63:0] o_data,
    input  logic        i_ready
);
    import tea_pkg::*;

    logic [63:0] r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        w_pop;

    assign w_pop   = (r_cnt != 2'd0) && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2) || w_pop)
        else $error("push into full output buffer");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt == 2'd0) || (r_cnt == 2'd2)) |-> (r_wp == r_rp))
        else $error("output buffer pointers disagree with count");

endmodule

>>> rtl/tea_block_cipher.sv
// TEA block cipher top level: key registers, half-round cell chain, output buffer.
//
//  channel    dir  handshake                       payload
//  s_axis     in   i_s_axis_tvalid/o_s_axis_tready  tdata {block_high, block_low}, tuser action
//  m_axis     out  o_m_axis_tvalid/i_m_axis_tready  tdata {out_high, out_low}
//  cfg        in   i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// One block accepted per cycle while the output buffer is not full; each block passes through
// the register of every half-round cell in the chain and then the output buffer.
// Reset (synchronous, active low) empties the chain and loads the default key.
// The whole chain advances together; it stalls only while the two-entry output
// buffer is full, so o_s_axis_tready comes from a register, not from i_m_axis_tready.
module tea_block_cipher #(
    parameter int unsigned ROUNDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] block_low, [63:32] block_high
    input  logic        i_s_axis_tuser,   // [0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] out_low, [63:32] out_high
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tea_pkg::*;

    localparam int unsigned NS = 2 * ROUNDS;

    t_key          r_key;
    logic [NS:0]   w_valid;
    t_blk          w_blk [NS+1];
    logic          w_en;
    logic          w_full;

    // Key registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[REG_KEY0] <= KEY0_RST;
            r_key[REG_KEY1] <= KEY1_RST;
            r_key[REG_KEY2] <= KEY2_RST;
            r_key[REG_KEY3] <= KEY3_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_KEY0: r_key[REG_KEY0] <= i_cfg_data;
                REG_KEY1: r_key[REG_KEY1] <= i_cfg_data;
                REG_KEY2: r_key[REG_KEY2] <= i_cfg_data;
                REG_KEY3: r_key[REG_KEY3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Chain input
    assign w_en            = !w_full;
    assign o_s_axis_tready = w_en;
    assign w_valid[0]      = i_s_axis_tvalid;
    assign w_blk[0].action = t_action'(i_s_axis_tuser);
    assign w_blk[0].v0     = i_s_axis_tdata[31:0];
    assign w_blk[0].v1     = i_s_axis_tdata[63:32];

    // Half-round cells, two per round
    for (genvar h = 0; h < NS; h++) begin : g_cell
        localparam int unsigned RND = h / 2;
        localparam logic [63:0] PE  = 64'(TEA_DELTA) * 64'(RND + 1);
        localparam logic [63:0] PD  = 64'(TEA_DELTA) * 64'(ROUNDS - RND);

        tea_cell #(
            .P_SUM_ENC (PE[31:0]),
            .P_SUM_DEC (PD[31:0]),
            .P_HALF    (1'((h % 2) == 1))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_key   (r_key),
            .i_valid (w_valid[h]),
            .i_blk   (w_blk[h]),
            .o_valid (w_valid[h+1]),
            .o_blk   (w_blk[h+1])
        );
    end

    // Result buffer
    tea_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && w_valid[NS]),
        .i_data  ({w_blk[NS].v1, w_blk[NS].v0}),
        .o_full  (w_full),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .i_ready (i_m_axis_tready)
    );

endmodule
